@@ rtl/clps_pkg.sv @@
// ----------------------------------------------------------------------------
// clps_pkg: shared types, codes and microcode for the print sequencer
// Holds the command and display-operation codes, the control word layout and
// the read-only microprogram that steps the datapath through each request.
// ----------------------------------------------------------------------------
package clps_pkg;

   localparam int DEFAULT_DISPLAY_COLS = 16;
   localparam int DEFAULT_DISPLAY_ROWS = 2;

   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_NL    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_SPACE = 8'h20;

   localparam logic [5:0] COL_MAX = 6'd63;

   typedef enum logic [1:0] {
      CMD_STRING    = 2'd0,
      CMD_STRING_AT = 2'd1,
      CMD_LINE      = 2'd2,
      CMD_CHAR      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_CURSOR = 2'd1,
      OP_DATA   = 2'd2,
      OP_DONE   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_START,
      ACT_CLEAR,
      ACT_CURSOR_START,
      ACT_BUMP_IDX,
      ACT_DATA,
      ACT_NEWLINE,
      ACT_CR,
      ACT_PAD,
      ACT_DONE
   } act_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_CLEAR,
      COND_PLAIN,
      COND_IDLE,
      COND_LINE,
      COND_CH_ZERO,
      COND_CH_NL,
      COND_CH_CR,
      COND_ROW_LAST,
      COND_IDX_FULL
   } cond_type;

   typedef logic [4:0] addr_type;

   // Program entry points and branch targets.
   localparam addr_type P_START = 5'd0;
   localparam addr_type P_POS   = 5'd2;
   localparam addr_type P_CHAR  = 5'd4;
   localparam addr_type P_NL    = 5'd10;
   localparam addr_type P_CR    = 5'd12;
   localparam addr_type P_DONE  = 5'd13;
   localparam addr_type P_LINE  = 5'd14;
   localparam addr_type P_LCHK  = 5'd18;
   localparam addr_type P_LCR   = 5'd20;
   localparam addr_type P_PAD   = 5'd21;
   localparam addr_type P_END   = 5'd23;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      addr_type target;
      logic     fin;
   } uop_type;

   typedef struct packed {
      logic no_clear;
      logic plain;
      logic idle;
      logic line;
      logic ch_zero;
      logic ch_nl;
      logic ch_cr;
      logic row_last;
      logic idx_full;
   } flags_type;

   typedef struct packed {
      logic    busy;
      logic    step;
      act_type act;
      logic    fin;
   } ctrl_type;

   typedef struct packed {
      op_type     lcd_op;
      logic [7:0] data_byte;
      logic [1:0] row;
      logic [5:0] col;
   } result_type;

   typedef struct packed {
      logic       wants;
      result_type res;
   } emit_type;

   function automatic uop_type mk_uop(act_type act, cond_type cond, addr_type target,
                                      logic fin);
      uop_type u;
      u.act    = act;
      u.cond   = cond;
      u.target = target;
      u.fin    = fin;
      return u;
   endfunction

   // Each word performs its action, then branches to target when its
   // condition holds and falls through otherwise.
   function automatic uop_type ucode_word(addr_type pc);
      uop_type u;
      unique case (pc)
         5'd0:    u = mk_uop(ACT_START,        COND_NO_CLEAR, P_POS,  1'b0);
         5'd1:    u = mk_uop(ACT_CLEAR,        COND_NEVER,    P_END,  1'b0);
         5'd2:    u = mk_uop(ACT_NONE,         COND_PLAIN,    P_END,  1'b0);
         5'd3:    u = mk_uop(ACT_CURSOR_START, COND_ALWAYS,   P_END,  1'b0);
         5'd4:    u = mk_uop(ACT_NONE,         COND_IDLE,     P_END,  1'b0);
         5'd5:    u = mk_uop(ACT_NONE,         COND_LINE,     P_LINE, 1'b0);
         5'd6:    u = mk_uop(ACT_BUMP_IDX,     COND_CH_ZERO,  P_DONE, 1'b0);
         5'd7:    u = mk_uop(ACT_NONE,         COND_CH_NL,    P_NL,   1'b0);
         5'd8:    u = mk_uop(ACT_NONE,         COND_CH_CR,    P_CR,   1'b0);
         5'd9:    u = mk_uop(ACT_DATA,         COND_ALWAYS,   P_END,  1'b0);
         5'd10:   u = mk_uop(ACT_NONE,         COND_ROW_LAST, P_DONE, 1'b0);
         5'd11:   u = mk_uop(ACT_NEWLINE,      COND_ALWAYS,   P_END,  1'b0);
         5'd12:   u = mk_uop(ACT_CR,           COND_ALWAYS,   P_END,  1'b0);
         5'd13:   u = mk_uop(ACT_DONE,         COND_ALWAYS,   P_END,  1'b0);
         5'd14:   u = mk_uop(ACT_NONE,         COND_IDX_FULL, P_DONE, 1'b0);
         5'd15:   u = mk_uop(ACT_NONE,         COND_CH_ZERO,  P_PAD,  1'b0);
         5'd16:   u = mk_uop(ACT_BUMP_IDX,     COND_CH_CR,    P_LCR,  1'b0);
         5'd17:   u = mk_uop(ACT_DATA,         COND_NEVER,    P_END,  1'b0);
         5'd18:   u = mk_uop(ACT_NONE,         COND_IDX_FULL, P_DONE, 1'b0);
         5'd19:   u = mk_uop(ACT_NONE,         COND_ALWAYS,   P_END,  1'b0);
         5'd20:   u = mk_uop(ACT_CR,           COND_ALWAYS,   P_LCHK, 1'b0);
         5'd21:   u = mk_uop(ACT_NONE,         COND_IDX_FULL, P_DONE, 1'b0);
         5'd22:   u = mk_uop(ACT_PAD,          COND_ALWAYS,   P_PAD,  1'b0);
         5'd23:   u = mk_uop(ACT_NONE,         COND_NEVER,    P_END,  1'b1);
         default: u = mk_uop(ACT_NONE,         COND_NEVER,    P_END,  1'b1);
      endcase
      return u;
   endfunction

   function automatic logic act_emits(act_type act);
      logic e;
      unique case (act)
         ACT_CLEAR, ACT_CURSOR_START, ACT_DATA, ACT_NEWLINE,
         ACT_CR, ACT_PAD, ACT_DONE: e = 1'b1;
         default:                   e = 1'b0;
      endcase
      return e;
   endfunction

endpackage

@@ rtl/char_lcd_print_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_print_sequencer: text to character-display command sequencer
// Turns start and character requests into clear, set-cursor, data-write and
// done commands for a character display of DISPLAY_COLS by DISPLAY_ROWS.
// ----------------------------------------------------------------------------
// A start request (plain string, string at row and column, or whole line)
// optionally emits a clear when csr_wr_data was last written as 1, and the
// positioned and line modes then emit a set-cursor. Each character request
// emits one data write, a cursor move for newline or carriage return, or done;
// line mode pads with spaces to DISPLAY_COLS and ends there. The rsp_last_result
// bit marks the final command of each request, and requests that produce no
// command (a plain start without clear, a character while idle) give no
// response at all. Control comes from a microcode table stepped once per
// clock unless stalled, so one request occupies the block until its program
// reaches its final step; line padding emits one space per padded column. A
// finished command sits in the output register while the next request is
// accepted; the sequencer only stalls when a held command must move on (a
// second command is ready or the program ends) and the output is still full.
// ----------------------------------------------------------------------------
module char_lcd_print_sequencer #(
   parameter int DISPLAY_COLS = clps_pkg::DEFAULT_DISPLAY_COLS,
   parameter int DISPLAY_ROWS = clps_pkg::DEFAULT_DISPLAY_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   // Configuration: auto clear enable.
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   // Request channel.
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [1:0] req_start_row,
   input  logic [5:0] req_start_col,
   input  logic [7:0] req_char_code,
   // Response channel.
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_lcd_op,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_cursor_row_out,
   output logic [5:0] rsp_cursor_col_out,
   output logic       rsp_last_result
);
   import clps_pkg::*;

   ctrl_type   ctrl;
   flags_type  flags;
   emit_type   emit;
   result_type rsp_res;
   logic       stall;
   logic       req_accept;

   // A new request is taken only once the previous program has finished.
   assign req_ready  = !ctrl.busy;
   assign req_accept = req_valid && req_ready;

   clps_ucode u_ucode (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_command (req_command),
      .flags       (flags),
      .stall       (stall),
      .ctrl        (ctrl)
   );

   clps_datapath #(
      .DISPLAY_COLS (DISPLAY_COLS),
      .DISPLAY_ROWS (DISPLAY_ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_accept    (req_accept),
      .req_command   (req_command),
      .req_start_row (req_start_row),
      .req_start_col (req_start_col),
      .req_char_code (req_char_code),
      .ctrl          (ctrl),
      .flags         (flags),
      .emit          (emit)
   );

   clps_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .emit      (emit),
      .stall     (stall),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res),
      .rsp_last  (rsp_last_result)
   );

   assign rsp_lcd_op         = rsp_res.lcd_op;
   assign rsp_data_byte      = rsp_res.data_byte;
   assign rsp_cursor_row_out = rsp_res.row;
   assign rsp_cursor_col_out = rsp_res.col;

endmodule

@@ rtl/clps_ucode.sv @@
// ----------------------------------------------------------------------------
// clps_ucode: microprogram sequencer
// Holds the step counter, reads the control word from the microcode table and
// resolves conditional branches against the datapath flags.
// ----------------------------------------------------------------------------
module clps_ucode (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  logic [1:0]          req_command,
   input  clps_pkg::flags_type flags,
   input  logic                stall,
   output clps_pkg::ctrl_type  ctrl
);
   import clps_pkg::*;

   addr_type pc_ff, pc_in;
   logic     busy_ff, busy_in;
   uop_type  uop;
   logic     cond_true;
   logic     step;

   assign uop  = ucode_word(pc_ff);
   assign step = busy_ff && !stall;

   always_comb begin
      unique case (uop.cond)
         COND_NEVER:    cond_true = 1'b0;
         COND_ALWAYS:   cond_true = 1'b1;
         COND_NO_CLEAR: cond_true = flags.no_clear;
         COND_PLAIN:    cond_true = flags.plain;
         COND_IDLE:     cond_true = flags.idle;
         COND_LINE:     cond_true = flags.line;
         COND_CH_ZERO:  cond_true = flags.ch_zero;
         COND_CH_NL:    cond_true = flags.ch_nl;
         COND_CH_CR:    cond_true = flags.ch_cr;
         COND_ROW_LAST: cond_true = flags.row_last;
         COND_IDX_FULL: cond_true = flags.idx_full;
         default:       cond_true = 1'b0;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
         pc_in   = (cmd_type'(req_command) == CMD_CHAR) ? P_CHAR : P_START;
      end else if (step) begin
         if (uop.fin) begin
            busy_in = 1'b0;
         end else if (cond_true) begin
            pc_in = uop.target;
         end else begin
            pc_in = pc_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= P_START;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign ctrl.busy = busy_ff;
   assign ctrl.step = step;
   assign ctrl.act  = uop.act;
   assign ctrl.fin  = uop.fin;

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= P_END)
      else $error("step counter left the microprogram");

   a_fin_ends_run: assert property (@(posedge clock) disable iff (reset)
      step && uop.fin |=> !busy_ff)
      else $error("sequencer still busy after final step");

endmodule

@@ rtl/clps_datapath.sv @@
// ----------------------------------------------------------------------------
// clps_datapath: print state and command formation
// Keeps the print mode, cursor position and character count, executes the
// action of each control word and forms the display command it emits.
// ----------------------------------------------------------------------------
module clps_datapath #(
   parameter int DISPLAY_COLS = clps_pkg::DEFAULT_DISPLAY_COLS,
   parameter int DISPLAY_ROWS = clps_pkg::DEFAULT_DISPLAY_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                req_accept,
   input  logic [1:0]          req_command,
   input  logic [1:0]          req_start_row,
   input  logic [5:0]          req_start_col,
   input  logic [7:0]          req_char_code,
   input  clps_pkg::ctrl_type  ctrl,
   output clps_pkg::flags_type flags,
   output clps_pkg::emit_type  emit
);
   import clps_pkg::*;

   // Latched request payload.
   cmd_type    cmd_ff;
   logic [1:0] srow_ff;
   logic [5:0] scol_ff;
   logic [7:0] ch_ff;

   logic       clear_en_ff;
   cmd_type    mode_ff, mode_in;
   logic       active_ff, active_in;
   logic [5:0] idx_ff, idx_in;
   logic [1:0] row_ff, row_in;
   logic [5:0] col_ff, col_in;

   logic [7:0] ch_resolved;
   logic [5:0] idx_inc;
   logic [5:0] col_inc;
   logic [5:0] start_col;

   // Line mode writes a newline as a space; other modes branch away first.
   assign ch_resolved = (ch_ff == CHR_NL) ? CHR_SPACE : ch_ff;
   assign idx_inc     = (idx_ff != COL_MAX) ? idx_ff + 6'd1 : idx_ff;
   assign col_inc     = (col_ff != COL_MAX) ? col_ff + 6'd1 : col_ff;
   assign start_col   = (cmd_ff == CMD_STRING_AT) ? scol_ff : 6'd0;

   assign flags.no_clear = !clear_en_ff;
   assign flags.plain    = (cmd_ff == CMD_STRING);
   assign flags.idle     = !active_ff;
   assign flags.line     = (mode_ff == CMD_LINE);
   assign flags.ch_zero  = (ch_ff == CHR_NUL);
   assign flags.ch_nl    = (ch_ff == CHR_NL);
   assign flags.ch_cr    = (ch_ff == CHR_CR);
   assign flags.row_last = ({1'b0, row_ff} + 3'd1) >= 3'(DISPLAY_ROWS);
   assign flags.idx_full = {1'b0, idx_ff} >= 7'(DISPLAY_COLS);

   always_comb begin
      emit.wants         = act_emits(ctrl.act);
      emit.res.lcd_op    = OP_DONE;
      emit.res.data_byte = 8'd0;
      emit.res.row       = 2'd0;
      emit.res.col       = 6'd0;
      unique case (ctrl.act)
         ACT_CLEAR: begin
            emit.res.lcd_op = OP_CLEAR;
         end
         ACT_CURSOR_START: begin
            emit.res.lcd_op = OP_CURSOR;
            emit.res.row    = srow_ff;
            emit.res.col    = start_col;
         end
         ACT_NEWLINE: begin
            emit.res.lcd_op = OP_CURSOR;
            emit.res.row    = row_ff + 2'd1;
         end
         ACT_CR: begin
            emit.res.lcd_op = OP_CURSOR;
            emit.res.row    = row_ff;
         end
         ACT_DATA: begin
            emit.res.lcd_op    = OP_DATA;
            emit.res.data_byte = ch_resolved;
         end
         ACT_PAD: begin
            emit.res.lcd_op    = OP_DATA;
            emit.res.data_byte = CHR_SPACE;
         end
         default: begin
            emit.res.lcd_op = OP_DONE;
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (ctrl.step) begin
         unique case (ctrl.act)
            ACT_START: begin
               mode_in   = cmd_ff;
               active_in = 1'b1;
               idx_in    = 6'd0;
            end
            ACT_CLEAR: begin
               row_in = 2'd0;
               col_in = 6'd0;
            end
            ACT_CURSOR_START: begin
               row_in = srow_ff;
               col_in = start_col;
            end
            ACT_BUMP_IDX: begin
               idx_in = idx_inc;
            end
            ACT_DATA: begin
               col_in = col_inc;
            end
            ACT_NEWLINE: begin
               row_in = row_ff + 2'd1;
               col_in = 6'd0;
            end
            ACT_CR: begin
               col_in = 6'd0;
            end
            ACT_PAD: begin
               idx_in = idx_inc;
               col_in = col_inc;
            end
            ACT_DONE: begin
               active_in = 1'b0;
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_en_ff <= 1'b0;
         mode_ff     <= CMD_STRING;
         active_ff   <= 1'b0;
         idx_ff      <= 6'd0;
         row_ff      <= 2'd0;
         col_ff      <= 6'd0;
      end else begin
         if (csr_wr_en) begin
            clear_en_ff <= csr_wr_data;
         end
         mode_ff   <= mode_in;
         active_ff <= active_in;
         idx_ff    <= idx_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= cmd_type'(req_command);
         srow_ff <= req_start_row;
         scol_ff <= req_start_col;
         ch_ff   <= req_char_code;
      end
   end

endmodule

@@ rtl/clps_out_stage.sv @@
// ----------------------------------------------------------------------------
// clps_out_stage: result holding and output register
// Holds the newest command until the next one or the end of the program shows
// whether it is the last of its request, then hands it to the output register.
// ----------------------------------------------------------------------------
module clps_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  clps_pkg::ctrl_type ctrl,
   input  clps_pkg::emit_type emit,
   output logic               stall,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output clps_pkg::result_type rsp_res,
   output logic               rsp_last
);
   import clps_pkg::*;

   result_type pend_ff;
   logic       pend_valid_ff, pend_valid_in;
   result_type out_ff;
   logic       out_last_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;
   logic       need_move;
   logic       move;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign need_move = pend_valid_ff && ctrl.busy && (emit.wants || ctrl.fin);
   assign stall     = need_move && !out_free;
   assign move      = ctrl.step && need_move;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (ctrl.step && emit.wants) begin
         pend_valid_in = 1'b1;
      end else if (ctrl.step && ctrl.fin) begin
         pend_valid_in = 1'b0;
      end
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step && emit.wants) begin
         pend_ff <= emit.res;
      end
      if (move) begin
         out_ff      <= pend_ff;
         out_last_ff <= ctrl.fin;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_ff;
   assign rsp_last  = out_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      move |-> out_free)
      else $error("held result moved into a full output register");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !ctrl.busy |-> !pend_valid_ff)
      else $error("result left behind after the program ended");

endmodule
